@@ rtl/core/mwo_pkg.sv @@
package mwo_pkg;

  typedef struct packed {
    logic signed [15:0] wheel_rpm_0;
    logic signed [15:0] wheel_rpm_1;
    logic signed [15:0] wheel_rpm_2;
    logic signed [15:0] wheel_rpm_3;
    logic [23:0]        elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_rate;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic [31:0]        heading;
  } out_item_t;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_SPEED_PER_RPM = 2'd0;
  localparam logic [1:0] REG_INVERSE_FOUR_LEVER = 2'd1;

  // datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_WHEEL = 4'd2;
  localparam logic [3:0] OP_SUMS = 4'd3;
  localparam logic [3:0] OP_RATE = 4'd4;
  localparam logic [3:0] OP_TSTEP = 4'd5;
  localparam logic [3:0] OP_DELTA = 4'd6;
  localparam logic [3:0] OP_HEAD = 4'd7;
  localparam logic [3:0] OP_CORDIC = 4'd8;
  localparam logic [3:0] OP_ROT = 4'd9;
  localparam logic [3:0] OP_VW = 4'd10;
  localparam logic [3:0] OP_POS = 4'd11;
  localparam logic [3:0] OP_DONE = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] idx;
  } dp_cmd_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd536870912;  5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;  5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;   5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;   5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;    5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;    5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;    5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;     5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;     5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;       5'd21: v = 30'd326;
      5'd22: v = 30'd163;       5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/mwo_ctrl.sv @@
module mwo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output mwo_pkg::dp_cmd_t cmd
);
  import mwo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WHEEL = 4'd1;
  localparam logic [3:0] S_SUMS = 4'd2;
  localparam logic [3:0] S_RATE = 4'd3;
  localparam logic [3:0] S_TSTEP = 4'd4;
  localparam logic [3:0] S_DELTA = 4'd5;
  localparam logic [3:0] S_HEAD = 4'd6;
  localparam logic [3:0] S_CORDIC = 4'd7;
  localparam logic [3:0] S_ROT = 4'd8;
  localparam logic [3:0] S_VW = 4'd9;
  localparam logic [3:0] S_POS = 4'd10;
  localparam logic [3:0] S_WAIT = 4'd11;

  logic [3:0] state, state_next;
  logic [4:0] idx, idx_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    idx_next = idx;
    out_valid_next = out_valid && out_stall;
    cmd.op = OP_NONE;
    cmd.idx = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_WHEEL;
          idx_next = '0;
        end
      end
      S_WHEEL: begin
        cmd.op = OP_WHEEL;
        idx_next = idx + 5'd1;
        if (idx == 5'd3) begin
          state_next = S_SUMS;
          idx_next = '0;
        end
      end
      S_SUMS: begin cmd.op = OP_SUMS; state_next = S_RATE; end
      S_RATE: begin cmd.op = OP_RATE; state_next = S_TSTEP; end
      S_TSTEP: begin cmd.op = OP_TSTEP; state_next = S_DELTA; end
      S_DELTA: begin cmd.op = OP_DELTA; state_next = S_HEAD; end
      S_HEAD: begin cmd.op = OP_HEAD; state_next = S_CORDIC; idx_next = '0; end
      S_CORDIC: begin
        cmd.op = OP_CORDIC;
        idx_next = idx + 5'd1;
        if (idx == 5'(CORDIC_STEPS - 1)) begin
          state_next = S_ROT;
          idx_next = '0;
        end
      end
      S_ROT: begin
        cmd.op = OP_ROT;
        idx_next = idx + 5'd1;
        if (idx == 5'd3) begin
          state_next = S_VW;
          idx_next = '0;
        end
      end
      S_VW: begin cmd.op = OP_VW; state_next = S_POS; end
      S_POS: begin
        cmd.op = OP_POS;
        idx_next = idx + 5'd1;
        if (idx == 5'd1) begin
          state_next = S_WAIT;
          idx_next = '0;
        end
      end
      S_WAIT: begin
        if (!out_valid || !out_stall) begin
          cmd.op = OP_DONE;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

@@ rtl/core/mwo_datapath.sv @@
module mwo_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mwo_pkg::dp_cmd_t    cmd,
  input  mwo_pkg::in_item_t   in_data,
  input  logic [23:0]         speed_per_rpm,
  input  logic [23:0]         inverse_four_lever,
  output mwo_pkg::out_item_t  out_data
);
  import mwo_pkg::*;

  in_item_t            item;
  logic signed [39:0]  w [4];
  logic signed [31:0]  vx, vy, vw;
  logic signed [42:0]  sx, sy, sw;
  logic signed [63:0]  t;
  logic signed [31:0]  delta;
  logic [31:0]         head;
  logic signed [33:0]  cx, cy;
  logic signed [32:0]  cz;
  logic                flip;
  logic signed [63:0]  prod [4];
  logic signed [33:0]  vxw, vyw;
  logic signed [31:0]  px, py;

  logic signed [15:0]  rpm_sel;
  logic signed [33:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [66:0]  mul_p;
  logic signed [42:0]  sw_hi;
  logic [23:0]         sw_lo;
  logic signed [18:0]  hi_s;
  logic signed [24:0]  lev_s;
  logic signed [43:0]  rate_hi;
  logic [47:0]         rate_lo;
  logic signed [34:0]  xs, ys;
  logic signed [33:0]  cx_n, cy_n;
  logic signed [32:0]  cz_n;
  logic [31:0]         q;
  logic signed [31:0]  hsel;
  logic signed [64:0]  acc;
  logic signed [31:0]  cos_v, sin_v;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    case (cmd.idx[1:0])
      2'd0: rpm_sel = item.wheel_rpm_0;
      2'd1: rpm_sel = item.wheel_rpm_1;
      2'd2: rpm_sel = item.wheel_rpm_2;
      default: rpm_sel = item.wheel_rpm_3;
    endcase
    sw_hi = sw >>> 24;
    sw_lo = sw[23:0];
    hi_s = sw_hi[18:0];
    lev_s = {1'b0, inverse_four_lever};
    rate_hi = hi_s * lev_s;
    rate_lo = sw_lo * inverse_four_lever;
    cos_v = flip ? -cx[31:0] : cx[31:0];
    sin_v = flip ? -cy[31:0] : cy[31:0];
    q = head + 32'h40000000;
    hsel = q[31] ? $signed(head ^ 32'h80000000) : $signed(head);
    xs = 35'(cx) >>> cmd.idx;
    ys = 35'(cy) >>> cmd.idx;
    if (!cz[32]) begin
      cx_n = 34'(cx - ys);
      cy_n = 34'(cy + xs);
      cz_n = cz - $signed({3'b000, atan_turn(cmd.idx)});
    end else begin
      cx_n = 34'(cx + ys);
      cy_n = 34'(cy - xs);
      cz_n = cz + $signed({3'b000, atan_turn(cmd.idx)});
    end
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_WHEEL: begin
        mul_a = 34'(rpm_sel);
        mul_b = $signed({9'd0, speed_per_rpm});
      end
      OP_TSTEP: begin
        mul_a = 34'(vw);
        mul_b = $signed({9'd0, item.elapsed_time});
      end
      OP_DELTA: begin
        mul_a = 34'(t);
        mul_b = $signed({1'b0, TURN_PER_RAD});
      end
      OP_ROT: begin
        case (cmd.idx[1:0])
          2'd0: begin mul_a = 34'(vx); mul_b = 33'(cos_v); end
          2'd1: begin mul_a = 34'(vy); mul_b = 33'(sin_v); end
          2'd2: begin mul_a = 34'(vx); mul_b = 33'(sin_v); end
          default: begin mul_a = 34'(vy); mul_b = 33'(cos_v); end
        endcase
      end
      OP_POS: begin
        mul_a = cmd.idx[0] ? vyw : vxw;
        mul_b = $signed({9'd0, item.elapsed_time});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    acc = cmd.idx[0] ? 65'(py) + 65'(mul_p >>> 32) : 65'(px) + 65'(mul_p >>> 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      head <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: item <= in_data;
        OP_WHEEL: w[cmd.idx[1:0]] <= mul_p[39:0];
        OP_SUMS: begin
          sx <= 43'(w[1]) + 43'(w[2]) - 43'(w[0]) - 43'(w[3]);
          sy <= 43'(w[0]) + 43'(w[1]) - 43'(w[2]) - 43'(w[3]);
          sw <= 43'(w[0]) + 43'(w[1]) + 43'(w[2]) + 43'(w[3]);
        end
        OP_RATE: begin
          vx <= sat32(65'(sx >>> 2));
          vy <= sat32(65'(sy >>> 2));
          vw <= sat32((65'(rate_hi) <<< 4) + $signed(65'(rate_lo >> 20)));
        end
        OP_TSTEP: t <= 64'(mul_p >>> 24);
        OP_DELTA: delta <= mul_p[55:24];
        OP_HEAD: head <= head + delta;
        OP_CORDIC: begin
          if (cmd.idx == '0) begin
            flip <= q[31];
            if (!hsel[31]) begin
              cx <= CORDIC_INV_GAIN;
              cy <= CORDIC_INV_GAIN;
              cz <= 33'(hsel) - 33'sd536870912;
            end else begin
              cx <= CORDIC_INV_GAIN;
              cy <= -CORDIC_INV_GAIN;
              cz <= 33'(hsel) + 33'sd536870912;
            end
          end else begin
            cx <= cx_n;
            cy <= cy_n;
            cz <= cz_n;
          end
        end
        OP_ROT: prod[cmd.idx[1:0]] <= 64'(mul_p);
        OP_VW: begin
          vxw <= 34'((prod[0] - prod[1]) >>> 30);
          vyw <= 34'((prod[2] + prod[3]) >>> 30);
        end
        OP_POS: begin
          if (cmd.idx[0]) py <= sat32(acc);
          else px <= sat32(acc);
        end
        OP_DONE: begin
          out_data.body_vx <= vx;
          out_data.body_vy <= vy;
          out_data.body_rate <= vw;
          out_data.world_x <= px;
          out_data.world_y <= py;
          out_data.heading <= head;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/mecanum_wheel_odometry_core.sv @@
// Mecanum odometry core. Each item takes four wheel speeds and an elapsed time
// and returns one result; one item is in work at a time, so a new item is
// taken only after the last result has been issued, and later still while a
// result waits on a stalled receiver. Throughput is set by the 24-step CORDIC
// iterating in one shared rotator plus a shared multiplier used for the wheel,
// heading, rotation and position products in turn (the body-rate products use
// their own multipliers). Positions and heading reset to zero.
module mecanum_wheel_odometry_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mwo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mwo_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mwo_pkg::*;

  logic [23:0] speed_per_rpm;
  logic [23:0] inverse_four_lever;
  dp_cmd_t     cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_per_rpm <= 24'd6990;
      inverse_four_lever <= 24'd655360;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SPEED_PER_RPM[0]: speed_per_rpm <= pwdata[23:0];
        default: inverse_four_lever <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INVERSE_FOUR_LEVER[0]: prdata = {8'd0, inverse_four_lever};
      default: prdata = {8'd0, speed_per_rpm};
    endcase
  end

  mwo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  mwo_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(in_data),
    .speed_per_rpm(speed_per_rpm), .inverse_four_lever(inverse_four_lever),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");
`endif
endmodule
